### src/fipf_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the firmware image page framer.
package fipf_pkg;

  // Result kinds
  localparam logic [2:0] KIND_ERASE = 3'd0;
  localparam logic [2:0] KIND_DATA  = 3'd1;
  localparam logic [2:0] KIND_END   = 3'd2;
  localparam logic [2:0] KIND_ERROR = 3'd3;
  localparam logic [2:0] KIND_DONE  = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_HEADER_SIG = 2'd0;
  localparam logic [1:0] ERR_CHUNK_SIG  = 2'd1;
  localparam logic [1:0] ERR_UNALIGNED  = 2'd2;

  // Signatures
  localparam logic [31:0] HEADER_SIG = 32'h5349_4654;
  localparam logic [31:0] CHUNK_SIG  = 32'h5343_4654;

  // Header byte positions
  localparam logic [5:0] POS_SIG_END   = 6'd3;
  localparam logic [5:0] POS_COUNT_END = 6'd55;
  localparam logic [5:0] POS_HDR_LAST  = 6'd63;
  localparam logic [5:0] POS_ADDR_END  = 6'd7;
  localparam logic [5:0] POS_SIZE_END  = 6'd11;
  localparam logic [5:0] POS_CHDR_LAST = 6'd15;

  // Most results one image byte can cause
  localparam int MAX_RESULTS = 3;

  // One result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] frame_page;
    logic [15:0] page_count;
    logic [7:0]  byte_offset;
    logic [7:0]  data_byte;
    logic [7:0]  page_checksum;
    logic [7:0]  pad_bytes;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

endpackage

### src/firmware_image_page_framer_top.sv
`timescale 1ns / 1ps
// Firmware image page framer: header parser, page framing and result queue.
//
// Usage: image bytes enter on the input channel (in_valid/in_ready), one beat
// per byte; image_start high marks header byte 0 of a new image and restarts
// the parser. Results leave on the output channel (out_valid/out_ready), one
// beat per result: erase commands, page data bytes, page ends with checksum
// and pad count, errors and image done. The last field marks the final
// result that one input byte caused.
// A result is registered in the result queue when its byte is accepted.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver takes every result. A byte that causes more than one
// result (up to three) holds in_ready low while the output port drains one
// result per cycle, when out_ready is high, from the four-entry result queue.
// The queue takes a new byte whenever at least three entries are free, so a
// byte is still accepted while one finished result waits on a stalled
// receiver; a longer stall fills the queue and in_ready drops.
// Reset clears the parser to idle and empties the queue; bytes before the
// first image_start, after an error or after image done cause no result.
// PAGE_BYTES must be a power of two.
module firmware_image_page_framer_top #(
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  image_byte,
  input  logic        image_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] frame_page,
  output logic [15:0] page_count,
  output logic [7:0]  byte_offset,
  output logic [7:0]  data_byte,
  output logic [7:0]  page_checksum,
  output logic [7:0]  pad_bytes,
  output logic [1:0]  error_code,
  output logic        last
);
  import fipf_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int OFF_W = $clog2(PAGE_BYTES + 1);
  localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Parser phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_CHUNK  = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_HALT   = 3'd5;

  logic [2:0]       phase, phase_next;
  logic [5:0]       hdr_cnt, hdr_cnt_next;
  logic [31:0]      word, word_next;
  logic [31:0]      chunks_total, chunks_total_next;
  logic [31:0]      chunks_done, chunks_done_next;
  logic [31:0]      chunk_addr, chunk_addr_next;
  logic [31:0]      bytes_left, bytes_left_next;
  logic [15:0]      cur_page, cur_page_next;
  logic [OFF_W-1:0] page_off, page_off_next;
  logic [7:0]       checksum, checksum_next;

  result_t          res [MAX_RESULTS];
  logic [1:0]       res_n;

  result_t          q [QDEPTH];
  logic [QCNT_W-1:0] q_cnt;
  logic             push, pop;

  // Working values for the current byte
  logic [2:0]       ph_eff;
  logic [5:0]       idx_eff;
  logic [31:0]      word_eff, ct_eff, cd_eff, cd_inc;
  logic [31:0]      page_of_addr, pages_of_size;
  logic [15:0]      new_page;
  logic [OFF_W-1:0] off_inc;
  logic [31:0]      off_ext, pad_full, bl_dec;
  logic [7:0]       cks_inc;
  logic [1:0]       done_slot;

  assign in_ready  = (q_cnt <= QCNT_W'(QDEPTH - MAX_RESULTS));
  assign push      = in_valid && in_ready;
  assign out_valid = (q_cnt != '0);
  assign pop       = out_valid && out_ready;

  // Parser step: next state and the results this byte causes.
  always_comb begin
    ph_eff   = image_start ? PH_HEADER : phase;
    idx_eff  = image_start ? 6'd0 : hdr_cnt;
    word_eff = image_start ? 32'd0 : word;
    ct_eff   = image_start ? 32'd0 : chunks_total;
    cd_eff   = image_start ? 32'd0 : chunks_done;
    cd_inc   = cd_eff + 32'd1;

    phase_next        = ph_eff;
    hdr_cnt_next      = idx_eff;
    word_next         = word_eff;
    chunks_total_next = ct_eff;
    chunks_done_next  = cd_eff;
    chunk_addr_next   = chunk_addr;
    bytes_left_next   = bytes_left;
    cur_page_next     = cur_page;
    page_off_next     = page_off;
    checksum_next     = checksum;

    page_of_addr  = chunk_addr >> PAGE_SHIFT;
    pages_of_size = (bytes_left >> PAGE_SHIFT) +
                    32'((bytes_left & PAGE_MASK) != 32'd0);
    new_page      = cur_page + 16'd1;
    off_inc       = page_off + OFF_W'(1);
    off_ext       = 32'(page_off);
    pad_full      = 32'(PAGE_BYTES) - 32'(off_inc);
    bl_dec        = bytes_left - 32'd1;
    cks_inc       = checksum + image_byte;
    done_slot     = 2'd0;

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    res_n = 2'd0;

    unique case (ph_eff)
      PH_HEADER: begin
        word_next    = {image_byte, word_eff[31:8]};
        hdr_cnt_next = idx_eff + 6'd1;
        if (idx_eff == POS_SIG_END && word_next != HEADER_SIG) begin
          res[0].kind       = KIND_ERROR;
          res[0].error_code = ERR_HEADER_SIG;
          res_n             = 2'd1;
          phase_next        = PH_HALT;
        end else if (idx_eff == POS_COUNT_END) begin
          chunks_total_next = word_next;
        end else if (idx_eff == POS_HDR_LAST) begin
          hdr_cnt_next = 6'd0;
          if (ct_eff == 32'd0) begin
            res[0].kind = KIND_DONE;
            res_n       = 2'd1;
            phase_next  = PH_DONE;
          end else begin
            phase_next = PH_CHUNK;
          end
        end
      end
      PH_CHUNK: begin
        word_next    = {image_byte, word_eff[31:8]};
        hdr_cnt_next = idx_eff + 6'd1;
        if (idx_eff == POS_SIG_END && word_next != CHUNK_SIG) begin
          res[0].kind       = KIND_ERROR;
          res[0].error_code = ERR_CHUNK_SIG;
          res_n             = 2'd1;
          phase_next        = PH_HALT;
        end else if (idx_eff == POS_ADDR_END) begin
          chunk_addr_next = word_next;
        end else if (idx_eff == POS_SIZE_END) begin
          bytes_left_next = word_next;
        end else if (idx_eff >= POS_CHDR_LAST) begin
          hdr_cnt_next = 6'd0;
          if ((chunk_addr & PAGE_MASK) != 32'd0) begin
            res[0].kind       = KIND_ERROR;
            res[0].error_code = ERR_UNALIGNED;
            res_n             = 2'd1;
            phase_next        = PH_HALT;
          end else begin
            // Erase command, then open the first page of the chunk.
            cur_page_next     = page_of_addr[15:0];
            res[0].kind       = KIND_ERASE;
            res[0].frame_page = page_of_addr[15:0];
            res[0].page_count = pages_of_size[15:0];
            res_n             = 2'd1;
            page_off_next     = '0;
            checksum_next     = page_of_addr[15:8] + page_of_addr[7:0];
            if (bytes_left == 32'd0) begin
              chunks_done_next = cd_inc;
              if (cd_inc == ct_eff) begin
                res[1].kind = KIND_DONE;
                res_n       = 2'd2;
                phase_next  = PH_DONE;
              end else begin
                phase_next = PH_CHUNK;
              end
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        // Data byte into the current page.
        res[0].kind        = KIND_DATA;
        res[0].frame_page  = cur_page;
        res[0].byte_offset = off_ext[7:0];
        res[0].data_byte   = image_byte;
        res_n              = 2'd1;
        checksum_next      = cks_inc;
        page_off_next      = off_inc;
        bytes_left_next    = bl_dec;
        // Page end on a full page or the last byte of the chunk.
        if (off_inc == OFF_W'(PAGE_BYTES) || bl_dec == 32'd0) begin
          res[1].kind          = KIND_END;
          res[1].frame_page    = cur_page;
          res[1].page_checksum = cks_inc;
          res[1].pad_bytes     = pad_full[7:0];
          res_n                = 2'd2;
          cur_page_next        = new_page;
          page_off_next        = '0;
          checksum_next        = new_page[15:8] + new_page[7:0];
          if (bl_dec == 32'd0) begin
            chunks_done_next = cd_inc;
            hdr_cnt_next     = 6'd0;
            if (cd_inc == ct_eff) begin
              res[2].kind = KIND_DONE;
              res_n       = 2'd3;
              phase_next  = PH_DONE;
            end else begin
              phase_next = PH_CHUNK;
            end
          end
        end
      end
      default: begin
        // Idle, done or halted: the byte is dropped.
      end
    endcase

    // Mark the final result of this byte.
    if (res_n != 2'd0) begin
      done_slot = res_n - 2'd1;
      res[done_slot].last = 1'b1;
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hdr_cnt      <= '0;
      word         <= '0;
      chunks_total <= '0;
      chunks_done  <= '0;
      chunk_addr   <= '0;
      bytes_left   <= '0;
      cur_page     <= '0;
      page_off     <= '0;
      checksum     <= '0;
    end else if (push) begin
      phase        <= phase_next;
      hdr_cnt      <= hdr_cnt_next;
      word         <= word_next;
      chunks_total <= chunks_total_next;
      chunks_done  <= chunks_done_next;
      chunk_addr   <= chunk_addr_next;
      bytes_left   <= bytes_left_next;
      cur_page     <= cur_page_next;
      page_off     <= page_off_next;
      checksum     <= checksum_next;
    end
  end

  // Result queue: head at entry 0, shifts down on each output beat.
  logic [QCNT_W-1:0] q_fill;
  logic [QCNT_W-1:0] q_add;
  logic [QCNT_W-1:0] q_rel [QDEPTH];

  always_comb begin
    q_fill = q_cnt - QCNT_W'(pop);
    q_add  = push ? QCNT_W'(res_n) : '0;
    for (int i = 0; i < QDEPTH; i++) begin
      q_rel[i] = QCNT_W'(i) - q_fill;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (push && QCNT_W'(i) >= q_fill && QCNT_W'(i) < q_fill + q_add) begin
        q[i] <= res[q_rel[i][QIDX_W-1:0]];
      end else if (pop && i < QDEPTH - 1) begin
        q[i] <= q[(i + 1) % QDEPTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_fill + q_add;
    end
  end

  // Output fields from the queue head
  assign kind          = q[0].kind;
  assign frame_page    = q[0].frame_page;
  assign page_count    = q[0].page_count;
  assign byte_offset   = q[0].byte_offset;
  assign data_byte     = q[0].data_byte;
  assign page_checksum = q[0].page_checksum;
  assign pad_bytes     = q[0].pad_bytes;
  assign error_code    = q[0].error_code;
  assign last          = q[0].last;

endmodule

### tb/sv/fipf_frame_checker.sv
`timescale 1ns / 1ps
// Result checker for the firmware image page framer: predicts frames from accepted bytes.
module fipf_frame_checker #(
  parameter int PAGE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  image_byte,
  input  logic        image_start,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] frame_page,
  input  logic [15:0] page_count,
  input  logic [7:0]  byte_offset,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  page_checksum,
  input  logic [7:0]  pad_bytes,
  input  logic [1:0]  error_code,
  input  logic        last,
  output int          errors,
  output int          pending
);
  import fipf_pkg::*;

  localparam logic [31:0] PAGE_SIZE = PAGE_BYTES;
  localparam int PRINT_LIMIT = 40;

  // Predicted parser phases
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HEADER = 3'd1;
  localparam logic [2:0] ST_CHUNK  = 3'd2;
  localparam logic [2:0] ST_DATA   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_HALT   = 3'd5;

  // Predicted parser state.
  logic [2:0]   state;
  logic [5:0]   hdr_pos;
  logic [31:0]  shift_word;
  logic [31:0]  chunks_total;
  logic [31:0]  chunks_done;
  logic [31:0]  chunk_addr;
  logic [31:0]  bytes_left;
  logic [15:0]  page_num;
  logic [12:0]  page_fill;
  logic [7:0]   page_sum;

  // Results of the current byte, and all results still owed by the block.
  result_t step_results[$];
  result_t frames_due[$];
  int      beat_no = 0;
  int      mismatch_count = 0;

  function automatic result_t blank_result(logic [2:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic void clear_parser();
    state        = ST_IDLE;
    hdr_pos      = '0;
    shift_word   = '0;
    chunks_total = '0;
    chunks_done  = '0;
    chunk_addr   = '0;
    bytes_left   = '0;
    page_num     = '0;
    page_fill    = '0;
    page_sum     = '0;
  endfunction

  // A fresh page starts its checksum with both page index bytes.
  function automatic void open_page();
    page_fill = '0;
    page_sum  = page_num[15:8] + page_num[7:0];
  endfunction

  function automatic void close_chunk();
    chunks_done = chunks_done + 32'd1;
    if (chunks_done == chunks_total) begin
      step_results.push_back(blank_result(KIND_DONE));
      state = ST_DONE;
    end else begin
      state   = ST_CHUNK;
      hdr_pos = '0;
    end
  endfunction

  // Work out every result one accepted image byte causes.
  function automatic void frame_byte(logic [7:0] b, logic st);
    logic [5:0] pos;
    result_t    r;
    step_results.delete();
    if (st) begin
      clear_parser();
      state = ST_HEADER;
    end
    unique case (state)
      ST_HEADER: begin
        shift_word = {b, shift_word[31:8]};
        pos        = hdr_pos;
        hdr_pos    = hdr_pos + 6'd1;
        if (pos == POS_SIG_END && shift_word != HEADER_SIG) begin
          r = blank_result(KIND_ERROR);
          r.error_code = ERR_HEADER_SIG;
          step_results.push_back(r);
          state = ST_HALT;
        end else if (pos == POS_COUNT_END) begin
          chunks_total = shift_word;
        end else if (pos == POS_HDR_LAST) begin
          hdr_pos = '0;
          if (chunks_total == 0) begin
            step_results.push_back(blank_result(KIND_DONE));
            state = ST_DONE;
          end else begin
            state = ST_CHUNK;
          end
        end
      end
      ST_CHUNK: begin
        shift_word = {b, shift_word[31:8]};
        pos        = hdr_pos;
        hdr_pos    = hdr_pos + 6'd1;
        if (pos == POS_SIG_END && shift_word != CHUNK_SIG) begin
          r = blank_result(KIND_ERROR);
          r.error_code = ERR_CHUNK_SIG;
          step_results.push_back(r);
          state = ST_HALT;
        end else if (pos == POS_ADDR_END) begin
          chunk_addr = shift_word;
        end else if (pos == POS_SIZE_END) begin
          bytes_left = shift_word;
        end else if (pos >= POS_CHDR_LAST) begin
          hdr_pos = '0;
          if (chunk_addr % PAGE_SIZE != 0) begin
            r = blank_result(KIND_ERROR);
            r.error_code = ERR_UNALIGNED;
            step_results.push_back(r);
            state = ST_HALT;
          end else begin
            page_num = 16'(chunk_addr / PAGE_SIZE);
            r = blank_result(KIND_ERASE);
            r.frame_page = page_num;
            r.page_count = 16'(bytes_left / PAGE_SIZE +
                               ((bytes_left % PAGE_SIZE != 0) ? 32'd1 : 32'd0));
            step_results.push_back(r);
            open_page();
            if (bytes_left == 0) begin
              close_chunk();
            end else begin
              state = ST_DATA;
            end
          end
        end
      end
      ST_DATA: begin
        r = blank_result(KIND_DATA);
        r.frame_page  = page_num;
        r.byte_offset = page_fill[7:0];
        r.data_byte   = b;
        step_results.push_back(r);
        page_sum   = page_sum + b;
        page_fill  = page_fill + 13'd1;
        bytes_left = bytes_left - 32'd1;
        // A full page, or the end of the chunk, closes the page frame.
        if (page_fill >= PAGE_SIZE || bytes_left == 0) begin
          r = blank_result(KIND_END);
          r.frame_page    = page_num;
          r.page_checksum = page_sum;
          r.pad_bytes     = 8'(PAGE_SIZE - 32'(page_fill));
          step_results.push_back(r);
          page_num = page_num + 16'd1;
          open_page();
          if (bytes_left == 0) begin
            close_chunk();
          end
        end
      end
      default: begin
      end
    endcase
    // The final result of this byte carries the last flag.
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) frames_due.push_back(step_results[i]);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] frame mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                beat_no, name, got, want));
    end
  endtask

  // Compare one result beat with the oldest expected result.
  task automatic compare_beat();
    result_t want;
    beat_no++;
    if (frames_due.size() == 0) begin
      report_mismatch($sformatf("result %0d of kind %0d came with none expected",
                                beat_no, kind));
    end else begin
      want = frames_due.pop_front();
      check_field("kind", 16'(kind), 16'(want.kind));
      check_field("frame_page", frame_page, want.frame_page);
      check_field("page_count", page_count, want.page_count);
      check_field("byte_offset", 16'(byte_offset), 16'(want.byte_offset));
      check_field("data_byte", 16'(data_byte), 16'(want.data_byte));
      check_field("page_checksum", 16'(page_checksum), 16'(want.page_checksum));
      check_field("pad_bytes", 16'(pad_bytes), 16'(want.pad_bytes));
      check_field("error_code", 16'(error_code), 16'(want.error_code));
      check_field("last", 16'(last), 16'(want.last));
    end
  endtask

  // Watch both channels; values are sampled as they stood before the edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      frames_due.delete();
      beat_no = 0;
    end else begin
      if (in_valid && in_ready) begin
        frame_byte(image_byte, image_start);
      end
      if (out_valid && out_ready) begin
        compare_beat();
      end
    end
    pending <= frames_due.size();
    errors  <= mismatch_count;
  end

endmodule

### tb/sv/tb_firmware_image_page_framer_top.sv
`timescale 1ns / 1ps
// Testbench top for the firmware image page framer: image stimulus, back-pressure and verdict.
module tb_firmware_image_page_framer_top;
  import fipf_pkg::*;

  localparam int PAGE_BYTES   = 256;
  localparam int ITEM_TARGET  = 410;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 20;

  typedef enum {
    IMG_GOOD, IMG_EMPTY, IMG_BAD_HEADER, IMG_BAD_CHUNK, IMG_UNALIGNED, IMG_CUT
  } image_flavor_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  image_byte = '0;
  logic        image_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [15:0] frame_page;
  logic [15:0] page_count;
  logic [7:0]  byte_offset;
  logic [7:0]  data_byte;
  logic [7:0]  page_checksum;
  logic [7:0]  pad_bytes;
  logic [1:0]  error_code;
  logic        last;

  int         errors;
  int         pending;
  int         bytes_sent = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  bit         long_hold = 1'b0;
  logic [7:0] image_q[$];

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  firmware_image_page_framer_top #(
    .PAGE_BYTES(PAGE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .image_byte(image_byte),
    .image_start(image_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .frame_page(frame_page),
    .page_count(page_count),
    .byte_offset(byte_offset),
    .data_byte(data_byte),
    .page_checksum(page_checksum),
    .pad_bytes(pad_bytes),
    .error_code(error_code),
    .last(last)
  );

  fipf_frame_checker #(
    .PAGE_BYTES(PAGE_BYTES)
  ) frame_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .image_byte(image_byte),
    .image_start(image_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .frame_page(frame_page),
    .page_count(page_count),
    .byte_offset(byte_offset),
    .data_byte(data_byte),
    .page_checksum(page_checksum),
    .pad_bytes(pad_bytes),
    .error_code(error_code),
    .last(last),
    .errors(errors),
    .pending(pending)
  );

  // Idle gaps: mostly none or short, now and then long; none in a calm stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) image_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void push_random(int n);
    repeat (n) image_q.push_back(8'($urandom));
  endfunction

  // Image header: signature, 48 filler bytes, chunk count, 8 filler bytes.
  function automatic void push_header(logic [31:0] sig, logic [31:0] count);
    push_word(sig);
    push_random(48);
    push_word(count);
    push_random(8);
  endfunction

  function automatic void push_chunk(logic [31:0] sig, logic [31:0] addr,
                                     logic [31:0] size, int payload_len);
    push_word(sig);
    push_word(addr);
    push_word(size);
    push_random(4);
    push_random(payload_len);
  endfunction

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'hFFFF_FF00;
    if (r < 20) return 32'h0100_0000;
    if (r < 25) return 32'h0000_0000;
    return $urandom & ~32'(PAGE_BYTES - 1);
  endfunction

  // Chunk sizes stay small, with some around one page to cross page ends.
  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'd0;
    if (r < 72) return $urandom_range(1, 24);
    if (r < 80) return $urandom_range(PAGE_BYTES - 6, PAGE_BYTES + 6);
    return $urandom_range(25, 60);
  endfunction

  function automatic image_flavor_t pick_flavor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return IMG_GOOD;
    if (r < 60) return IMG_EMPTY;
    if (r < 70) return IMG_BAD_HEADER;
    if (r < 80) return IMG_BAD_CHUNK;
    if (r < 88) return IMG_UNALIGNED;
    return IMG_CUT;
  endfunction

  // Build one image: well formed with random content, or broken in one place.
  function automatic void build_image(image_flavor_t flavor);
    logic [31:0] count;
    logic [31:0] sig;
    logic [31:0] addr;
    logic [31:0] size;
    int          n_chunks;
    int          payload_len;
    int          keep;
    image_q.delete();
    case (flavor)
      IMG_EMPTY: count = '0;
      IMG_CUT:   count = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(1, 3));
      default:   count = $urandom_range(1, 3);
    endcase
    sig = HEADER_SIG;
    if (flavor == IMG_BAD_HEADER) sig = sig ^ (32'd1 << $urandom_range(0, 31));
    push_header(sig, count);
    if (flavor == IMG_BAD_HEADER) begin
      // Only a few bytes follow the broken signature.
      keep = $urandom_range(4, 8);
      while (image_q.size() > keep) void'(image_q.pop_back());
    end
    n_chunks = (flavor == IMG_EMPTY || flavor == IMG_BAD_HEADER) ? 0 :
               (count > 3) ? 2 : int'(count);
    for (int c = 0; c < n_chunks; c++) begin
      sig  = CHUNK_SIG;
      addr = pick_address();
      size = pick_size();
      payload_len = int'(size);
      if (c == n_chunks - 1) begin
        if (flavor == IMG_BAD_CHUNK) begin
          sig = sig ^ (32'd1 << $urandom_range(0, 31));
          payload_len = $urandom_range(0, 3);
        end
        if (flavor == IMG_UNALIGNED) begin
          addr = addr | 32'($urandom_range(1, PAGE_BYTES - 1));
          payload_len = $urandom_range(0, 3);
        end
        if (flavor == IMG_CUT && $urandom_range(0, 1) == 1) begin
          size = $urandom;
          payload_len = 40;
        end
      end
      push_chunk(sig, addr, size, payload_len);
    end
    if (flavor == IMG_CUT) begin
      // The next image start lands in the middle of this one.
      keep = $urandom_range(4, image_q.size() - 1);
      while (image_q.size() > keep) void'(image_q.pop_back());
    end
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_byte(logic [7:0] b, logic st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    image_byte  <= b;
    image_start <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the built image; at hold_at the receiver starts a long hold-off.
  task automatic send_image(int hold_at);
    foreach (image_q[i]) begin
      if (i == hold_at) long_hold = 1'b1;
      send_byte(image_q[i], i == 0);
    end
  endtask

  task automatic send_junk(int n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  // Stop offering beats until every expected result has been seen.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Bytes ahead of the first image start are dropped.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h54, 1'b0);

    // Header signature wrong in its top byte; the block then ignores bytes.
    image_q = {8'h54, 8'h46, 8'h49, 8'h00};
    send_image(-1);
    send_junk(2);

    // An image with no chunks is done right after its header.
    image_q.delete();
    push_header(HEADER_SIG, 32'd0);
    send_image(-1);
    send_junk(1);

    // Two chunks: the first page number wraps past 65535 and its data is sent
    // while the receiver holds off; the empty last chunk gives erase and
    // image done from one byte.
    image_q.delete();
    push_header(HEADER_SIG, 32'd2);
    push_chunk(CHUNK_SIG, 32'h0100_0000, 32'd20, 0);
    image_q.push_back(8'hFF);
    image_q.push_back(8'h00);
    push_random(18);
    push_chunk(CHUNK_SIG, 32'hFFFF_FF00, 32'd0, 0);
    send_image(64 + 16);
    wait_drained();

    // Chunk signature wrong.
    image_q.delete();
    push_header(HEADER_SIG, 32'd1);
    push_chunk(CHUNK_SIG ^ 32'h8000_0000, 32'd0, 32'd1, 0);
    send_image(-1);

    // Chunk address off a page boundary.
    image_q.delete();
    push_header(HEADER_SIG, 32'd1);
    push_chunk(CHUNK_SIG, 32'h0000_0080, 32'd4, 0);
    send_image(-1);
    wait_drained();

    // Random images, mostly well formed, some broken or cut short, until the
    // item budget is spent.
    while (bytes_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      build_image(pick_flavor());
      send_image(-1);
      if ($urandom_range(0, 9) < 4) send_junk($urandom_range(1, 3));
      if ($urandom_range(0, 9) < 3) wait_drained();
    end
    calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/fipf_pkg.sv
src/firmware_image_page_framer_top.sv
tb/sv/fipf_frame_checker.sv
tb/sv/tb_firmware_image_page_framer_top.sv
